// ----- design/pulst_pkg.sv -----
`timescale 1ns / 1ps
// per-user link statistics table: shared types, constants and row update functions
// no dependencies; used by per_user_link_stats_table, pulst_key_scan and pulst_counter_ram

package pulst_pkg;

	localparam int TABLE_ENTRIES_DEF = 16;
	localparam int NUM_COUNTERS      = 21;

	// opcodes of an input item
	localparam logic [1:0] OP_RECORD = 2'd0;
	localparam logic [1:0] OP_RESET  = 2'd1;
	localparam logic [1:0] OP_QUERY  = 2'd2;
	localparam logic [1:0] OP_NONE   = 2'd3;

	// counter positions within a row
	localparam logic [4:0] C_PDU       = 5'd0;
	localparam logic [4:0] C_INIT      = 5'd1;
	localparam logic [4:0] C_RETX      = 5'd2;
	localparam logic [4:0] C_VOL       = 5'd3;
	localparam logic [4:0] C_MOD_QPSK  = 5'd4;
	localparam logic [4:0] C_MOD_16QAM = 5'd5;
	localparam logic [4:0] C_MOD_64QAM = 5'd6;
	localparam logic [4:0] C_MCS       = 5'd7;
	localparam logic [4:0] C_SINR      = 5'd13;
	localparam logic [4:0] C_SYM       = 5'd20;

	// mcs range limits
	localparam logic [4:0] MCS_QPSK_MAX  = 5'd9;
	localparam logic [4:0] MCS_16QAM_MAX = 5'd16;
	localparam logic [4:0] MCS_64QAM_MAX = 5'd28;
	localparam logic [4:0] MCS_BIN_MAX   = 5'd29;

	// sinr bin upper edges in dB with 4 fraction bits, each inclusive
	localparam logic signed [11:0] SINR_EDGE_M6  = -12'sd96;
	localparam logic signed [11:0] SINR_EDGE_0   = 12'sd0;
	localparam logic signed [11:0] SINR_EDGE_6   = 12'sd96;
	localparam logic signed [11:0] SINR_EDGE_12  = 12'sd192;
	localparam logic signed [11:0] SINR_EDGE_18  = 12'sd288;
	localparam logic signed [11:0] SINR_EDGE_24  = 12'sd384;

	typedef logic [NUM_COUNTERS-1:0][31:0] row_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_ROW_RD,
		ST_ROW_UPD,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic done;
		logic hit;
		logic free_ok;
	} scan_res_t;

	typedef struct packed {
		logic        alloc;
		logic        free_entry;
		logic [15:0] user_id;
		logic [15:0] cell_id;
	} key_upd_t;

	// mcs / 5 for mcs up to 29
	function automatic logic [4:0] mcs_group(input logic [4:0] mcs);
		logic [4:0] g;
		if (mcs <= 5'd4)       g = 5'd0;
		else if (mcs <= 5'd9)  g = 5'd1;
		else if (mcs <= 5'd14) g = 5'd2;
		else if (mcs <= 5'd19) g = 5'd3;
		else if (mcs <= 5'd24) g = 5'd4;
		else                   g = 5'd5;
		return g;
	endfunction

	function automatic logic [4:0] sinr_bin(input logic signed [11:0] sinr);
		logic [4:0] b;
		if (sinr <= SINR_EDGE_M6)      b = 5'd0;
		else if (sinr <= SINR_EDGE_0)  b = 5'd1;
		else if (sinr <= SINR_EDGE_6)  b = 5'd2;
		else if (sinr <= SINR_EDGE_12) b = 5'd3;
		else if (sinr <= SINR_EDGE_18) b = 5'd4;
		else if (sinr <= SINR_EDGE_24) b = 5'd5;
		else                           b = 5'd6;
		return b;
	endfunction

	function automatic row_t row_update(
		input row_t                row,
		input logic [1:0]          rv,
		input logic [31:0]         bytes,
		input logic [4:0]          mcs,
		input logic signed [11:0]  sinr,
		input logic [3:0]          sym
	);
		row_t       r;
		logic [4:0] k;
		r = row;
		r[C_PDU] = r[C_PDU] + 32'd1;
		if (rv == 2'd0) begin
			r[C_INIT] = r[C_INIT] + 32'd1;
		end else begin
			r[C_RETX] = r[C_RETX] + 32'd1;
		end
		r[C_VOL] = r[C_VOL] + bytes;
		if (mcs <= MCS_QPSK_MAX) begin
			r[C_MOD_QPSK] = r[C_MOD_QPSK] + 32'd1;
		end else if (mcs <= MCS_16QAM_MAX) begin
			r[C_MOD_16QAM] = r[C_MOD_16QAM] + 32'd1;
		end else if (mcs <= MCS_64QAM_MAX) begin
			r[C_MOD_64QAM] = r[C_MOD_64QAM] + 32'd1;
		end
		if (mcs <= MCS_BIN_MAX) begin
			k = C_MCS + mcs_group(mcs);
			r[k] = r[k] + 32'd1;
		end
		k = C_SINR + sinr_bin(sinr);
		r[k] = r[k] + 32'd1;
		r[C_SYM] = r[C_SYM] + {28'd0, sym};
		return r;
	endfunction

endpackage

// ----- design/pulst_if.sv -----
`timescale 1ns / 1ps
// valid/ready channels of the per-user link statistics table
// no dependencies

interface pulst_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         opcode;
	logic [15:0]        user_id;
	logic [15:0]        cell_id;
	logic [31:0]        block_bytes;
	logic [4:0]         mcs_index;
	logic [1:0]         redundancy_version;
	logic signed [11:0] sinr_db;
	logic [3:0]         symbol_count;
	logic [4:0]         counter_select;

	modport source (
		output valid, opcode, user_id, cell_id, block_bytes, mcs_index,
			redundancy_version, sinr_db, symbol_count, counter_select,
		input ready
	);
	modport sink (
		input valid, opcode, user_id, cell_id, block_bytes, mcs_index,
			redundancy_version, sinr_db, symbol_count, counter_select,
		output ready
	);
endinterface

interface pulst_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] counter_value;
	logic        entry_found;
	logic        status;

	modport source (output valid, counter_value, entry_found, status, input ready);
	modport sink (input valid, counter_value, entry_found, status, output ready);
endinterface

// ----- design/per_user_link_stats_table.sv -----
`timescale 1ns / 1ps
// per-user link statistics table, key search one entry per cycle, one item in flight
// record (hit or free entry) or query hit: key search, row read, row update, then result load;
// reset, query miss, unused opcode or full table: key search, then result load
// the next input transfer follows the result load, which waits while a held result blocks
// the output register
// arst_n clears all valid flags and control state; counter rows are zeroed on allocation
// depends on pulst_pkg, pulst_if, pulst_key_scan, pulst_counter_ram

module per_user_link_stats_table #(
	parameter int TableEntries = pulst_pkg::TABLE_ENTRIES_DEF
) (
	input logic           clk,
	input logic           arst_n,
	pulst_req_if.sink     req,
	pulst_rsp_if.source   rsp
);

	localparam int IdxW = (TableEntries > 1) ? $clog2(TableEntries) : 1;

	pulst_pkg::state_t st_q, st_d;

	logic [1:0]         op_q;
	logic [15:0]        user_q;
	logic [15:0]        cell_q;
	logic [31:0]        bytes_q;
	logic [4:0]         mcs_q;
	logic [1:0]         rv_q;
	logic signed [11:0] sinr_q;
	logic [3:0]         sym_q;
	logic [4:0]         sel_q;

	logic [IdxW-1:0] slot_q;
	logic            fresh_q;
	logic [31:0]     res_value_q;
	logic            res_found_q;
	logic            res_status_q;

	logic        out_valid_q;
	logic [31:0] out_value_q;
	logic        out_found_q;
	logic        out_status_q;

	pulst_pkg::scan_res_t scan;
	pulst_pkg::key_upd_t  upd;
	logic [IdxW-1:0]      hit_idx;
	logic [IdxW-1:0]      free_idx;
	logic [IdxW-1:0]      upd_idx;
	logic                 scan_start;
	logic                 accept;
	logic                 decide;
	logic                 load_out;
	logic                 ram_rd_en;
	logic                 ram_wr_en;
	pulst_pkg::row_t      rd_row;
	pulst_pkg::row_t      wr_row;

	pulst_key_scan #(.TableEntries(TableEntries)) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (scan_start),
		.user_id  (req.user_id),
		.cell_id  (req.cell_id),
		.upd      (upd),
		.upd_idx  (upd_idx),
		.res      (scan),
		.hit_idx  (hit_idx),
		.free_idx (free_idx)
	);

	pulst_counter_ram #(.TableEntries(TableEntries)) u_ram (
		.clk    (clk),
		.rd_en  (ram_rd_en),
		.rd_idx (slot_q),
		.rd_row (rd_row),
		.wr_en  (ram_wr_en),
		.wr_idx (slot_q),
		.wr_row (wr_row)
	);

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			pulst_pkg::ST_IDLE: begin
				if (req.valid) begin
					st_d = pulst_pkg::ST_SCAN;
				end
			end
			pulst_pkg::ST_SCAN: begin
				if (scan.done) begin
					if (op_q == pulst_pkg::OP_RECORD && (scan.hit || scan.free_ok)) begin
						st_d = pulst_pkg::ST_ROW_RD;
					end else if (op_q == pulst_pkg::OP_QUERY && scan.hit) begin
						st_d = pulst_pkg::ST_ROW_RD;
					end else begin
						st_d = pulst_pkg::ST_DONE;
					end
				end
			end
			pulst_pkg::ST_ROW_RD:  st_d = pulst_pkg::ST_ROW_UPD;
			pulst_pkg::ST_ROW_UPD: st_d = pulst_pkg::ST_DONE;
			pulst_pkg::ST_DONE: begin
				if (!out_valid_q || rsp.ready) begin
					st_d = pulst_pkg::ST_IDLE;
				end
			end
			default: st_d = pulst_pkg::ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		req.ready      = (st_q == pulst_pkg::ST_IDLE);
		accept         = req.ready && req.valid;
		scan_start     = accept;
		decide         = (st_q == pulst_pkg::ST_SCAN) && scan.done;
		upd.alloc      = decide && (op_q == pulst_pkg::OP_RECORD) && !scan.hit
			&& scan.free_ok;
		upd.free_entry = decide && (op_q == pulst_pkg::OP_RESET) && scan.hit;
		upd.user_id    = user_q;
		upd.cell_id    = cell_q;
		upd_idx        = scan.hit ? hit_idx : free_idx;
		ram_rd_en      = (st_q == pulst_pkg::ST_ROW_RD);
		ram_wr_en      = (st_q == pulst_pkg::ST_ROW_UPD) && (op_q == pulst_pkg::OP_RECORD);
		load_out       = (st_q == pulst_pkg::ST_DONE) && (!out_valid_q || rsp.ready);
	end

	// a freshly allocated entry starts from an all-zero row
	assign wr_row = pulst_pkg::row_update(fresh_q ? '0 : rd_row, rv_q, bytes_q, mcs_q,
		sinr_q, sym_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= pulst_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= req.opcode;
			user_q  <= req.user_id;
			cell_q  <= req.cell_id;
			bytes_q <= req.block_bytes;
			mcs_q   <= req.mcs_index;
			rv_q    <= req.redundancy_version;
			sinr_q  <= req.sinr_db;
			sym_q   <= req.symbol_count;
			sel_q   <= req.counter_select;
		end
		if (decide) begin
			slot_q       <= upd_idx;
			fresh_q      <= !scan.hit;
			res_value_q  <= '0;
			res_found_q  <= scan.hit && (op_q != pulst_pkg::OP_NONE);
			res_status_q <= (op_q == pulst_pkg::OP_RECORD) && !scan.hit && !scan.free_ok;
		end
		if (st_q == pulst_pkg::ST_ROW_UPD && op_q == pulst_pkg::OP_QUERY) begin
			if (sel_q < 5'(pulst_pkg::NUM_COUNTERS)) begin
				res_value_q <= rd_row[sel_q];
			end
		end
		if (load_out) begin
			out_value_q  <= res_value_q;
			out_found_q  <= res_found_q;
			out_status_q <= res_status_q;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.counter_value = out_value_q;
	assign rsp.entry_found   = out_found_q;
	assign rsp.status        = out_status_q;

endmodule

// ----- design/pulst_key_scan.sv -----
`timescale 1ns / 1ps
// key store (valid flags plus key memory) and the sequential key search
// depends on pulst_pkg

module pulst_key_scan #(
	parameter int TableEntries = pulst_pkg::TABLE_ENTRIES_DEF,
	localparam int IdxW = (TableEntries > 1) ? $clog2(TableEntries) : 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [15:0]          user_id,
	input  logic [15:0]          cell_id,
	input  pulst_pkg::key_upd_t  upd,
	input  logic [IdxW-1:0]      upd_idx,
	output pulst_pkg::scan_res_t res,
	output logic [IdxW-1:0]      hit_idx,
	output logic [IdxW-1:0]      free_idx
);

	localparam int CntW = $clog2(TableEntries + 1);

	logic [31:0]             key_mem [TableEntries];
	logic [TableEntries-1:0] valid_q;

	logic            busy_q;
	logic [CntW-1:0] cnt_q;
	logic            chk_s1;
	logic [IdxW-1:0] chk_idx_s1;
	logic [31:0]     rd_key_s1;
	logic [31:0]     key_q;
	logic            hit_q;
	logic            free_q;
	logic            done_q;
	logic [IdxW-1:0] hit_idx_q;
	logic [IdxW-1:0] free_idx_q;

	logic issue;
	logic hit_now;
	logic free_now;

	assign issue    = busy_q && (cnt_q != CntW'(TableEntries));
	assign hit_now  = chk_s1 && valid_q[chk_idx_s1] && (rd_key_s1 == key_q) && !hit_q;
	assign free_now = chk_s1 && !valid_q[chk_idx_s1] && !free_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			cnt_q   <= '0;
			chk_s1  <= 1'b0;
			hit_q   <= 1'b0;
			free_q  <= 1'b0;
			done_q  <= 1'b0;
			valid_q <= '0;
		end else begin
			done_q <= 1'b0;
			chk_s1 <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				hit_q  <= 1'b0;
				free_q <= 1'b0;
			end else if (busy_q) begin
				if (issue) begin
					chk_s1 <= 1'b1;
					cnt_q  <= cnt_q + 1'b1;
				end else begin
					// last compare happens in this cycle
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
			if (hit_now) begin
				hit_q <= 1'b1;
			end
			if (free_now) begin
				free_q <= 1'b1;
			end
			if (upd.alloc) begin
				valid_q[upd_idx] <= 1'b1;
			end else if (upd.free_entry) begin
				valid_q[upd_idx] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			key_q <= {user_id, cell_id};
		end
		if (issue) begin
			rd_key_s1  <= key_mem[cnt_q[IdxW-1:0]];
			chk_idx_s1 <= cnt_q[IdxW-1:0];
		end
		if (hit_now) begin
			hit_idx_q <= chk_idx_s1;
		end
		if (free_now) begin
			free_idx_q <= chk_idx_s1;
		end
		if (upd.alloc) begin
			key_mem[upd_idx] <= {upd.user_id, upd.cell_id};
		end
	end

	assign res.done    = done_q;
	assign res.hit     = hit_q;
	assign res.free_ok = free_q;
	assign hit_idx     = hit_idx_q;
	assign free_idx    = free_idx_q;

endmodule

// ----- design/pulst_counter_ram.sv -----
`timescale 1ns / 1ps
// counter memory: one row of all counters per table entry, registered read
// depends on pulst_pkg

module pulst_counter_ram #(
	parameter int TableEntries = pulst_pkg::TABLE_ENTRIES_DEF,
	localparam int IdxW = (TableEntries > 1) ? $clog2(TableEntries) : 1
) (
	input  logic              clk,
	input  logic              rd_en,
	input  logic [IdxW-1:0]   rd_idx,
	output pulst_pkg::row_t   rd_row,
	input  logic              wr_en,
	input  logic [IdxW-1:0]   wr_idx,
	input  pulst_pkg::row_t   wr_row
);

	pulst_pkg::row_t mem [TableEntries];
	pulst_pkg::row_t rd_row_q;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_row_q <= mem[rd_idx];
		end
		if (wr_en) begin
			mem[wr_idx] <= wr_row;
		end
	end

	assign rd_row = rd_row_q;

endmodule
